// ===== hdl/apd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package apd_pkg;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int SPEED_W    = 13;
    localparam int COMPARE_W  = 16;

    // Q9.7 angle times Q12.4 gain gives 11 fraction bits; rate term is 3 short
    localparam int FRAC_SHIFT = 11;
    localparam int D_ALIGN    = 3;

    // -85 degrees in Q9.7
    localparam logic signed [15:0] NEAR_THRESHOLD = -16'sd10880;

    // speeds at or above this drive as zero
    localparam int ZEROING_BOUND = 3199;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TILT         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN_FAR       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN_NEAR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_START_COMPARE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_START_COMPARE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SPEED_COMPARE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_COMPARE        = 3'd7;

    typedef struct packed {
        logic signed [15:0] tilt_angle;
        logic signed [15:0] tilt_rate;
    } sample_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_command;
        logic [COMPARE_W-1:0]      m1_fwd_compare;
        logic [COMPARE_W-1:0]      m1_back_compare;
        logic [COMPARE_W-1:0]      m2_fwd_compare;
        logic [COMPARE_W-1:0]      m2_back_compare;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/angle_pd_motor_pwm_drive_top.sv =====
// Channel   Direction  Handshake                    Payload
// sample    in         sample_valid / sample_stall  sample_t (tilt_angle, tilt_rate)
// result    out        result_valid / result_stall  result_t (speed, four compares)
// cfg       in         cfg_we                       cfg_index, cfg_data
//
// One sample per cycle unless result stalls; each beat is registered in both stages.
// Stage one holds the two gain products, stage two holds the finished result.
// A stalled result holds its stage; stage one still takes a beat while empty.
// rst_n clears both stage valids and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none

module angle_pd_motor_pwm_drive_top
    import apd_pkg::*;
#(
    parameter int SPEED_LIMIT = 2500
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sample_valid,
    output logic                      sample_stall,
    input  wire sample_t              sample,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output result_t                   result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int P_W    = 34;
    localparam int D_W    = 33;
    localparam int DIFF_W = 37;
    localparam int Q_W    = DIFF_W - FRAC_SHIFT;

    typedef struct packed {
        logic [COMPARE_W-1:0] fwd;
        logic [COMPARE_W-1:0] back;
    } motor_t;

    logic signed [15:0]   target_tilt_reg;
    logic [CFG_W-1:0]     angle_gain_reg;
    logic [CFG_W-1:0]     rate_gain_far_reg;
    logic [CFG_W-1:0]     rate_gain_near_reg;
    logic [COMPARE_W-1:0] left_start_reg;
    logic [COMPARE_W-1:0] right_start_reg;
    logic [COMPARE_W-1:0] full_speed_reg;
    logic [COMPARE_W-1:0] idle_reg;

    logic                 mid_valid_reg;
    logic signed [P_W-1:0] p_reg;
    logic signed [D_W-1:0] d_reg;
    logic signed [P_W-1:0] p_next;
    logic signed [D_W-1:0] d_next;

    logic                 result_valid_reg;
    result_t              result_reg;
    result_t              result_next;

    logic                 out_ready;
    logic                 mid_ready;
    logic                 sample_beat;

    logic signed [16:0]   angle_err;
    logic [CFG_W-1:0]     kd;

    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] biased;
    logic signed [Q_W-1:0]    quot;
    logic signed [Q_W-1:0]    limit_pos;
    logic signed [Q_W-1:0]    clamped;
    logic signed [SPEED_W-1:0] speed;
    logic signed [SPEED_W-1:0] drive;
    logic [SPEED_W-2:0]       mag;
    motor_t                   m1;
    motor_t                   m2;

    function automatic motor_t map_motor(
        input logic [COMPARE_W-1:0]  start,
        input logic [COMPARE_W-1:0]  full,
        input logic [COMPARE_W-1:0]  idle,
        input logic signed [SPEED_W-1:0] drv,
        input logic [SPEED_W-2:0]    amt
    );
        logic signed [COMPARE_W+1:0] c;
        logic signed [COMPARE_W+1:0] floor_c;
        motor_t m;
        c       = $signed({2'b00, start}) - $signed({{(COMPARE_W+2-(SPEED_W-1)){1'b0}}, amt});
        floor_c = $signed({2'b00, full});
        if (c < floor_c)
        begin
            c = floor_c;
        end
        if (drv > 0)
        begin
            m.fwd  = c[COMPARE_W-1:0];
            m.back = idle;
        end
        else if (drv < 0)
        begin
            m.fwd  = idle;
            m.back = c[COMPARE_W-1:0];
        end
        else
        begin
            m.fwd  = idle;
            m.back = idle;
        end
        return m;
    endfunction

    // pipeline flow control
    assign out_ready    = !result_valid_reg || !result_stall;
    assign mid_ready    = !mid_valid_reg || out_ready;
    assign sample_stall = !mid_ready;
    assign sample_beat  = sample_valid && mid_ready;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // stage one: the two gain products
    always_comb
    begin
        angle_err = 17'(target_tilt_reg) - 17'(sample.tilt_angle);
        kd        = (sample.tilt_angle > NEAR_THRESHOLD) ? rate_gain_far_reg : rate_gain_near_reg;
        p_next    = $signed({1'b0, angle_gain_reg}) * angle_err;
        d_next    = $signed({1'b0, kd}) * sample.tilt_rate;
    end

    // stage two: combine, truncate toward zero, clamp, map to compares
    always_comb
    begin
        diff   = DIFF_W'(p_reg) - (DIFF_W'(d_reg) <<< D_ALIGN);
        biased = diff + (diff[DIFF_W-1] ? DIFF_W'((1 << FRAC_SHIFT) - 1) : DIFF_W'(0));
        quot   = $signed(biased[DIFF_W-1:FRAC_SHIFT]);
        limit_pos = Q_W'(SPEED_LIMIT);
        if (quot > limit_pos)
        begin
            clamped = limit_pos;
        end
        else if (quot < -limit_pos)
        begin
            clamped = -limit_pos;
        end
        else
        begin
            clamped = quot;
        end
        speed = clamped[SPEED_W-1:0];
        drive = (speed >= $signed(SPEED_W'(ZEROING_BOUND))) ? '0 : speed;
        mag   = (SPEED_W-1)'(drive[SPEED_W-1] ? -drive : drive);
        m1    = map_motor(left_start_reg, full_speed_reg, idle_reg, drive, mag);
        m2    = map_motor(right_start_reg, full_speed_reg, idle_reg, drive, mag);

        result_next.speed_command   = speed;
        result_next.m1_fwd_compare  = m1.fwd;
        result_next.m1_back_compare = m1.back;
        result_next.m2_fwd_compare  = m2.fwd;
        result_next.m2_back_compare = m2.back;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_tilt_reg    <= -16'sd6400;
            angle_gain_reg     <= 16'd3520;
            rate_gain_far_reg  <= 16'd288;
            rate_gain_near_reg <= 16'd112;
            left_start_reg     <= 16'd3859;
            right_start_reg    <= 16'd3699;
            full_speed_reg     <= 16'd1199;
            idle_reg           <= 16'd3999;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET_TILT:         target_tilt_reg    <= $signed(cfg_data);
                REG_ANGLE_GAIN:          angle_gain_reg     <= cfg_data;
                REG_RATE_GAIN_FAR:       rate_gain_far_reg  <= cfg_data;
                REG_RATE_GAIN_NEAR:      rate_gain_near_reg <= cfg_data;
                REG_LEFT_START_COMPARE:  left_start_reg     <= cfg_data;
                REG_RIGHT_START_COMPARE: right_start_reg    <= cfg_data;
                REG_FULL_SPEED_COMPARE:  full_speed_reg     <= cfg_data;
                REG_IDLE_COMPARE:        idle_reg           <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (mid_ready)
            begin
                mid_valid_reg <= sample_valid;
            end
            if (out_ready)
            begin
                result_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_beat)
        begin
            p_reg <= p_next;
            d_reg <= d_next;
        end
        if (out_ready && mid_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/apd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apd_checker
    import apd_pkg::*;
#(
    parameter int SPEED_LIMIT = 2500
)
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    sample_valid,
    input wire logic    sample_stall,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    localparam logic signed [SPEED_W-1:0] LIM = SPEED_W'(SPEED_LIMIT);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

    // every sample beat reaches the output stage after passing through stage one
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |-> ##2 result_valid)
    else $error("sample beat not delivered in time");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.speed_command <= LIM && result.speed_command >= -LIM)
    else $error("speed command out of range");

    // idle channels match across motors; zero speed idles all four
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (result.speed_command > 0 && result.m1_back_compare == result.m2_back_compare)
         || (result.speed_command < 0 && result.m1_fwd_compare == result.m2_fwd_compare)
         || (result.speed_command == 0
             && result.m1_fwd_compare == result.m1_back_compare
             && result.m2_fwd_compare == result.m2_back_compare
             && result.m1_fwd_compare == result.m2_fwd_compare))
    else $error("compare values inconsistent with speed sign");

endmodule

bind angle_pd_motor_pwm_drive_top apd_checker #(.SPEED_LIMIT(SPEED_LIMIT)) u_apd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
